### rtl/ngh_pkg.sv
// Shared widths, reset values, codes and handshake structs of the noise gate.
package ngh_pkg;

    // Field and register widths
    localparam int SAMPLE_W    = 24;
    localparam int GAIN_FRAC_W = 16;
    localparam int GAIN_W      = GAIN_FRAC_W + 1;
    localparam int THR_W       = SAMPLE_W - 1;
    localparam int HOLD_W      = 20;
    localparam int POLE_W      = 16;
    localparam int ENV_W       = 32;
    localparam int ENV_GUARD   = ENV_W - SAMPLE_W;
    localparam int ENV_COEF_W  = 24;
    localparam int CNT_W       = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = THR_W;

    // Envelope update coefficient for the new magnitude (0.001 in Q0.24)
    localparam int ENV_COEF_NEW = 16777;

    // Reset values of the configuration registers
    localparam logic [THR_W-1:0]  OPEN_THR_RST  = THR_W'(8389);
    localparam logic [THR_W-1:0]  CLOSE_THR_RST = THR_W'(4195);
    localparam logic [HOLD_W-1:0] HOLD_RST      = HOLD_W'(4800);
    localparam logic [POLE_W-1:0] POLE_RST      = POLE_W'(65208);

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC_W;

    // Digit-serial multiplier geometry
    localparam int MUL_M_W   = 34;
    localparam int MUL_X_W   = 24;
    localparam int MUL_DIG_W = 8;
    localparam int MUL_NDIG  = MUL_X_W / MUL_DIG_W;
    localparam int MUL_CNT_W = $clog2(MUL_NDIG);
    localparam int MUL_PH_W  = MUL_M_W + MUL_DIG_W;
    localparam int MUL_P_W   = 64;

    // Datapath widths around the multiplier
    localparam int ACC_W   = 52;
    localparam int ENV_T_W = 50;
    localparam int OUT_T_W = SAMPLE_W + GAIN_W + 1;
    localparam int OUT_R_W = OUT_T_W - GAIN_FRAC_W;
    localparam int SAT_W   = OUT_R_W - SAMPLE_W + 1;

    // Rounding offsets
    localparam logic signed [ENV_T_W-1:0] ENV_HALF  = ENV_T_W'(1) << (ENV_COEF_W - 1);
    localparam logic signed [ACC_W-1:0]   GAIN_HALF = ACC_W'(1) << (2 * POLE_W - 1);
    localparam logic signed [OUT_T_W-1:0] OUT_HALF  = OUT_T_W'(1) << (GAIN_FRAC_W - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_THR  = 2'd0,
        CFG_CLOSE_THR = 2'd1,
        CFG_HOLD      = 2'd2,
        CFG_POLE      = 2'd3
    } t_cfg_idx;

    // Request to the shared multiplier
    typedef struct packed {
        logic                      start;
        logic signed [MUL_M_W-1:0] m;
        logic [MUL_X_W-1:0]        x;
    } t_mul_req;

    // Status from the shared multiplier
    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

endpackage

### rtl/ngh_in_if.sv
// Sample input channel: valid/ready handshake with one signed sample.
interface ngh_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ngh_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### rtl/ngh_out_if.sv
// Result output channel: valid/ready handshake with gated sample, gain and gate state.
interface ngh_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ngh_pkg::SAMPLE_W-1:0] gated_sample;
    logic [ngh_pkg::GAIN_W-1:0]          current_gain;
    logic                               gate_open;

    modport source (output valid, output gated_sample, output current_gain,
                    output gate_open, input ready);
    modport sink   (input valid, input gated_sample, input current_gain,
                    input gate_open, output ready);
endinterface

### rtl/ngh_smul.sv
// Digit-serial signed-by-unsigned multiplier, one 8-bit digit of the multiplier per cycle.
module ngh_smul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ngh_pkg::t_mul_req i_req,
    output ngh_pkg::t_mul_rsp o_rsp
);

    logic signed [ngh_pkg::MUL_M_W-1:0]  r_m;
    logic [ngh_pkg::MUL_X_W-1:0]         r_x;
    logic signed [ngh_pkg::MUL_PH_W-1:0] r_ph;
    logic [ngh_pkg::MUL_X_W-1:0]         r_pl;
    logic [ngh_pkg::MUL_CNT_W-1:0]       r_cnt;
    logic                                r_busy;
    logic                                r_done;

    logic [ngh_pkg::MUL_DIG_W-1:0]       w_dig;
    logic signed [ngh_pkg::MUL_PH_W:0]   n_sum;

    // Add one partial product of the lowest digit to the upper half
    assign w_dig = r_x[ngh_pkg::MUL_DIG_W-1:0];
    assign n_sum = r_ph + r_m * $signed({1'b0, w_dig});

    // Control: count digits, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ngh_pkg::MUL_CNT_W'(ngh_pkg::MUL_NDIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m  <= i_req.m;
            r_x  <= i_req.x;
            r_ph <= '0;
            r_pl <= '0;
        end else if (r_busy) begin
            r_x  <= r_x >> ngh_pkg::MUL_DIG_W;
            r_ph <= ngh_pkg::MUL_PH_W'(n_sum >>> ngh_pkg::MUL_DIG_W);
            r_pl <= {n_sum[ngh_pkg::MUL_DIG_W-1:0], r_pl[ngh_pkg::MUL_X_W-1:ngh_pkg::MUL_DIG_W]};
        end
    end

    // Product stays stable until the next start
    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_ph[ngh_pkg::MUL_P_W-ngh_pkg::MUL_X_W-1:0], r_pl};

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a preceding digit pass");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");
`endif

endmodule

### rtl/noise_gate_hold_smooth.sv
// Noise gate with hysteresis, hold count and two-pole gain smoothing.
// Each sample takes five passes through the shared digit-serial multiplier
//   (three 8-bit digits each) and the gate, gain, result and idle steps; the
//   result step waits until the output register is free, and a new sample is
//   accepted only in the idle step, once the last one has been fully processed.
// Reset (synchronous, active low): gate closed, envelope, hold count and gain
//   history cleared, registers back to their default thresholds, hold and pole.
module noise_gate_hold_smooth (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ngh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ngh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ngh_in_if.sink                         i_in,
    ngh_out_if.source                      o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_GATE  = 5'b00100,
        S_GAIN  = 5'b01000,
        S_DRAIN = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        OP_ENV = 3'd0,
        OP_PP  = 3'd1,
        OP_G2  = 3'd2,
        OP_G1  = 3'd3,
        OP_OUT = 3'd4
    } t_op;

    // Configuration
    logic [ngh_pkg::THR_W-1:0]  r_open_thr;
    logic [ngh_pkg::THR_W-1:0]  r_close_thr;
    logic [ngh_pkg::HOLD_W-1:0] r_hold;
    logic [ngh_pkg::POLE_W-1:0] r_pole;

    // Gate state
    logic [ngh_pkg::ENV_W-1:0]  r_env;
    logic                       r_open;
    logic [ngh_pkg::CNT_W-1:0]  r_below;
    logic                       r_target;
    logic [ngh_pkg::GAIN_W-1:0] r_g1;
    logic [ngh_pkg::GAIN_W-1:0] r_g2;

    // Sequencer and working registers
    t_state                                r_state;
    t_op                                   r_op;
    logic signed [ngh_pkg::SAMPLE_W-1:0]   r_s;
    logic signed [ngh_pkg::ACC_W-1:0]      r_acc;

    // Output register
    logic                                  r_ovalid;
    logic signed [ngh_pkg::SAMPLE_W-1:0]   r_out_sample;
    logic [ngh_pkg::GAIN_W-1:0]            r_out_gain;
    logic                                  r_out_open;

    ngh_pkg::t_mul_req                     w_req;
    ngh_pkg::t_mul_rsp                     w_rsp;

    logic                                  w_accept;
    logic [ngh_pkg::SAMPLE_W-1:0]          w_mag;
    logic signed [ngh_pkg::MUL_M_W-1:0]    w_diff;
    logic signed [ngh_pkg::ENV_T_W-1:0]    w_env_t;
    logic signed [ngh_pkg::MUL_M_W-1:0]    n_env_sum;
    logic [ngh_pkg::ENV_W-1:0]             n_env;
    logic                                  w_open_hit;
    logic                                  w_close_hit;
    logic [ngh_pkg::CNT_W-1:0]             n_cnt0;
    logic [ngh_pkg::CNT_W-1:0]             n_cnt1;
    logic                                  w_hold_over;
    logic [ngh_pkg::MUL_M_W-1:0]           w_qq;
    logic signed [ngh_pkg::ACC_W-1:0]      n_round;
    logic [ngh_pkg::ACC_W-33:0]            w_gain_raw;
    logic [ngh_pkg::GAIN_W-1:0]            n_gain;
    logic signed [ngh_pkg::OUT_T_W-1:0]    w_out_t;
    logic signed [ngh_pkg::OUT_R_W-1:0]    w_out_r;
    logic                                  w_out_ovf;
    logic signed [ngh_pkg::SAMPLE_W-1:0]   n_out_sample;
    logic                                  w_out_free;

    ngh_smul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Handshakes
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || o_out.ready;

    assign o_out.valid        = r_ovalid;
    assign o_out.gated_sample = r_out_sample;
    assign o_out.current_gain = r_out_gain;
    assign o_out.gate_open    = r_out_open;

    // Envelope: env' = env + round((|s|<<8 - env) * 0.001)
    assign w_mag  = i_in.sample[ngh_pkg::SAMPLE_W-1] ? (~i_in.sample + 1'b1) : i_in.sample;
    assign w_diff = $signed({2'b00, w_mag, {ngh_pkg::ENV_GUARD{1'b0}}})
                  - $signed({2'b00, r_env});
    assign w_env_t   = $signed(w_rsp.prod[ngh_pkg::ENV_T_W-1:0]) + ngh_pkg::ENV_HALF;
    assign n_env_sum = $signed({2'b00, r_env})
                     + ngh_pkg::MUL_M_W'($signed(w_env_t[ngh_pkg::ENV_T_W-1:ngh_pkg::ENV_COEF_W]));
    assign n_env     = n_env_sum[ngh_pkg::ENV_W-1:0];

    // Thresholds and hold count
    assign w_open_hit  = r_env >= ngh_pkg::ENV_W'({r_open_thr, {ngh_pkg::ENV_GUARD{1'b0}}});
    assign w_close_hit = r_env < ngh_pkg::ENV_W'({r_close_thr, {ngh_pkg::ENV_GUARD{1'b0}}});
    assign n_cnt0      = w_open_hit ? '0 : r_below;
    assign n_cnt1      = n_cnt0 + 1'b1;
    assign w_hold_over = n_cnt1 > ngh_pkg::CNT_W'(r_hold);

    // (1-p)^2 = 2^32 - 2p*2^16 + p^2
    assign w_qq = {2'b01, 32'h0} - {1'b0, r_pole, 17'h0} + {2'b00, w_rsp.prod[31:0]};

    // Smoothed gain: round, clamp to [0, unity]
    assign n_round    = r_acc + ngh_pkg::GAIN_HALF;
    assign w_gain_raw = n_round[ngh_pkg::ACC_W-1:32];
    always_comb begin
        if (r_acc[ngh_pkg::ACC_W-1] || (r_acc == '0)) begin
            n_gain = '0;
        end else if (w_gain_raw > (ngh_pkg::ACC_W-32)'(ngh_pkg::GAIN_UNITY)) begin
            n_gain = ngh_pkg::GAIN_UNITY;
        end else begin
            n_gain = w_gain_raw[ngh_pkg::GAIN_W-1:0];
        end
    end

    // Gated sample: round half up at the gain point, saturate
    assign w_out_t   = $signed(w_rsp.prod[ngh_pkg::OUT_T_W-1:0]) + ngh_pkg::OUT_HALF;
    assign w_out_r   = w_out_t[ngh_pkg::OUT_T_W-1:ngh_pkg::GAIN_FRAC_W];
    assign w_out_ovf = (w_out_r[ngh_pkg::OUT_R_W-1:ngh_pkg::SAMPLE_W-1] != '0)
                    && (w_out_r[ngh_pkg::OUT_R_W-1:ngh_pkg::SAMPLE_W-1] != {ngh_pkg::SAT_W{1'b1}});
    always_comb begin
        if (!w_out_ovf) begin
            n_out_sample = w_out_r[ngh_pkg::SAMPLE_W-1:0];
        end else if (w_out_r[ngh_pkg::OUT_R_W-1]) begin
            n_out_sample = {1'b1, {(ngh_pkg::SAMPLE_W-1){1'b0}}};
        end else begin
            n_out_sample = {1'b0, {(ngh_pkg::SAMPLE_W-1){1'b1}}};
        end
    end

    // Multiplier requests
    always_comb begin
        w_req       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_req.start = 1'b1;
                    w_req.m     = w_diff;
                    w_req.x     = ngh_pkg::MUL_X_W'(ngh_pkg::ENV_COEF_NEW);
                end
            end
            S_GATE: begin
                w_req.start = 1'b1;
                w_req.m     = ngh_pkg::MUL_M_W'(r_pole);
                w_req.x     = ngh_pkg::MUL_X_W'(r_pole);
            end
            S_MUL: begin
                if (w_rsp.done && (r_op == OP_PP)) begin
                    w_req.start = 1'b1;
                    w_req.m     = ngh_pkg::MUL_M_W'(w_rsp.prod[31:0]);
                    w_req.x     = ngh_pkg::MUL_X_W'(r_g2);
                end else if (w_rsp.done && (r_op == OP_G2)) begin
                    w_req.start = 1'b1;
                    w_req.m     = ngh_pkg::MUL_M_W'(r_pole);
                    w_req.x     = ngh_pkg::MUL_X_W'(r_g1);
                end
            end
            S_GAIN: begin
                w_req.start = 1'b1;
                w_req.m     = ngh_pkg::MUL_M_W'(r_s);
                w_req.x     = ngh_pkg::MUL_X_W'(n_gain);
            end
            S_DRAIN: begin
                w_req.start = 1'b0;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_thr  <= ngh_pkg::OPEN_THR_RST;
            r_close_thr <= ngh_pkg::CLOSE_THR_RST;
            r_hold      <= ngh_pkg::HOLD_RST;
            r_pole      <= ngh_pkg::POLE_RST;
        end else if (i_cfg_we) begin
            unique case (ngh_pkg::t_cfg_idx'(i_cfg_idx))
                ngh_pkg::CFG_OPEN_THR:  r_open_thr  <= i_cfg_data[ngh_pkg::THR_W-1:0];
                ngh_pkg::CFG_CLOSE_THR: r_close_thr <= i_cfg_data[ngh_pkg::THR_W-1:0];
                ngh_pkg::CFG_HOLD:      r_hold      <= i_cfg_data[ngh_pkg::HOLD_W-1:0];
                ngh_pkg::CFG_POLE:      r_pole      <= i_cfg_data[ngh_pkg::POLE_W-1:0];
                default: begin
                    r_hold <= r_hold;
                end
            endcase
        end
    end

    // Sequencer and gate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_ENV;
            r_env    <= '0;
            r_open   <= 1'b0;
            r_below  <= '0;
            r_target <= 1'b0;
            r_g1     <= '0;
            r_g2     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Drop the result once taken
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= OP_ENV;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_rsp.done) begin
                        unique case (r_op)
                            OP_ENV: begin
                                r_env   <= n_env;
                                r_state <= S_GATE;
                            end
                            OP_PP: begin
                                r_op <= OP_G2;
                            end
                            OP_G2: begin
                                r_op <= OP_G1;
                            end
                            OP_G1: begin
                                r_state <= S_GAIN;
                            end
                            OP_OUT: begin
                                r_state <= S_DRAIN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_GATE: begin
                    // Open first, then the close test may override it
                    if (w_open_hit) begin
                        r_open   <= 1'b1;
                        r_target <= 1'b1;
                        r_below  <= '0;
                    end
                    if (w_close_hit) begin
                        if (w_hold_over) begin
                            r_open   <= 1'b0;
                            r_target <= 1'b0;
                            r_below  <= '0;
                        end else begin
                            r_below <= n_cnt1;
                        end
                    end
                    r_op    <= OP_PP;
                    r_state <= S_MUL;
                end
                S_GAIN: begin
                    r_g2    <= r_g1;
                    r_g1    <= n_gain;
                    r_op    <= OP_OUT;
                    r_state <= S_MUL;
                end
                S_DRAIN: begin
                    // Hold the product until the output register frees up
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s <= i_in.sample;
        end
        if ((r_state == S_MUL) && w_rsp.done) begin
            case (r_op)
                OP_PP: begin
                    r_acc <= r_target ? ngh_pkg::ACC_W'({w_qq, {ngh_pkg::GAIN_FRAC_W{1'b0}}})
                                      : '0;
                end
                OP_G2: begin
                    r_acc <= r_acc - $signed(w_rsp.prod[ngh_pkg::ACC_W-1:0]);
                end
                OP_G1: begin
                    r_acc <= r_acc + $signed({w_rsp.prod[ngh_pkg::ACC_W-18:0], 17'h0});
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
        // Load the payload only when the previous result has left
        if ((r_state == S_DRAIN) && w_out_free) begin
            r_out_sample <= n_out_sample;
            r_out_gain   <= r_g1;
            r_out_open   <= r_open;
        end
    end

`ifndef SYNTHESIS
    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_MUL))
        else $error("multiplier finished outside a multiply step");

    a_open_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open == r_target)
        else $error("gate state and gain target disagree");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g1 <= ngh_pkg::GAIN_UNITY) && (r_g2 <= ngh_pkg::GAIN_UNITY))
        else $error("gain history above unity");

    a_drain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DRAIN) |-> ($past(r_state) == S_MUL) && ($past(r_op) == OP_OUT))
        else $error("result stage entered before the output product");
`endif

endmodule

### tb/ngh_gate_checker.sv
// Checker for the noise gate: predicts each result from the observed requests and compares it.
`timescale 1ns / 100ps

module ngh_gate_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ngh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ngh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ngh_in_if                              i_in_ch,
    ngh_out_if                             i_out_ch,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam longint ENV_KEEP = (longint'(1) << ngh_pkg::ENV_COEF_W) - ngh_pkg::ENV_COEF_NEW;

    typedef struct {
        logic signed [ngh_pkg::SAMPLE_W-1:0] gated;
        logic [ngh_pkg::GAIN_W-1:0]          gain;
        logic                                open;
    } t_gate_result;

    // Mirrored registers
    logic [ngh_pkg::THR_W-1:0]  open_thr;
    logic [ngh_pkg::THR_W-1:0]  close_thr;
    logic [ngh_pkg::HOLD_W-1:0] hold_len;
    logic [ngh_pkg::POLE_W-1:0] pole;

    // Mirrored gate state
    logic [ngh_pkg::ENV_W-1:0] env_lvl;
    logic                      open_st;
    logic [ngh_pkg::CNT_W-1:0] below_cnt;
    logic                      tgt_unity;
    longint                    g_last;
    longint                    g_prev;

    t_gate_result gated_results[$];
    int           mismatches;
    int           result_idx;

    assign o_fail_count = mismatches;
    assign o_pending    = gated_results.size();

    // Advance the mirrored gate by one sample and return the result it must produce
    function automatic t_gate_result gate_step(input logic signed [ngh_pkg::SAMPLE_W-1:0] s);
        t_gate_result res;
        longint       sv, p, q, acc, g, t, r, unity;
        logic [63:0]  mag, num;
        sv    = longint'(s);
        unity = longint'(1) << ngh_pkg::GAIN_FRAC_W;
        mag   = (sv < 0) ? 64'(-sv) : 64'(sv);

        // One-pole envelope of the magnitude, rounded half up
        num = 64'(env_lvl) * 64'(ENV_KEEP)
            + (mag << ngh_pkg::ENV_GUARD) * 64'(ngh_pkg::ENV_COEF_NEW)
            + (64'd1 << (ngh_pkg::ENV_COEF_W - 1));
        env_lvl = num[ngh_pkg::ENV_COEF_W +: ngh_pkg::ENV_W];

        // Open first, then count below the close level and close after the hold
        if (env_lvl >= (ngh_pkg::ENV_W'(open_thr) << ngh_pkg::ENV_GUARD)) begin
            open_st   = 1'b1;
            tgt_unity = 1'b1;
            below_cnt = '0;
        end
        if (env_lvl < (ngh_pkg::ENV_W'(close_thr) << ngh_pkg::ENV_GUARD)) begin
            below_cnt = below_cnt + 1'b1;
            if (below_cnt > ngh_pkg::CNT_W'(hold_len)) begin
                open_st   = 1'b0;
                tgt_unity = 1'b0;
                below_cnt = '0;
            end
        end

        // Two-pole smoother, clamped to [0, unity] for output and history
        p   = longint'(pole);
        q   = (longint'(1) << ngh_pkg::POLE_W) - p;
        acc = 2 * p * g_last * (longint'(1) << ngh_pkg::POLE_W) - p * p * g_prev
            + (tgt_unity ? q * q * unity : 0);
        if (acc <= 0)
            g = 0;
        else
            g = (acc + (longint'(1) << (2 * ngh_pkg::POLE_W - 1))) >>> (2 * ngh_pkg::POLE_W);
        if (g > unity)
            g = unity;
        g_prev = g_last;
        g_last = g;

        // Round half up: the floor of t covers both signs
        t = sv * g + (longint'(1) << (ngh_pkg::GAIN_FRAC_W - 1));
        r = t >>> ngh_pkg::GAIN_FRAC_W;
        if (r > (longint'(1) << (ngh_pkg::SAMPLE_W - 1)) - 1)
            r = (longint'(1) << (ngh_pkg::SAMPLE_W - 1)) - 1;
        if (r < -(longint'(1) << (ngh_pkg::SAMPLE_W - 1)))
            r = -(longint'(1) << (ngh_pkg::SAMPLE_W - 1));

        res.gated = ngh_pkg::SAMPLE_W'(r);
        res.gain  = ngh_pkg::GAIN_W'(g);
        res.open  = open_st;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint want_v, input longint got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     result_idx, field, want_v, got_v);
    endtask

    // Sample at the falling edge: a request seen here completes at the next rising edge
    always @(negedge i_clk) begin : watch
        t_gate_result want;
        if (!i_rst_n) begin
            open_thr   = ngh_pkg::OPEN_THR_RST;
            close_thr  = ngh_pkg::CLOSE_THR_RST;
            hold_len   = ngh_pkg::HOLD_RST;
            pole       = ngh_pkg::POLE_RST;
            env_lvl    = '0;
            open_st    = 1'b0;
            below_cnt  = '0;
            tgt_unity  = 1'b0;
            g_last     = 0;
            g_prev     = 0;
            result_idx = 0;
            gated_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (ngh_pkg::t_cfg_idx'(i_cfg_idx))
                    ngh_pkg::CFG_OPEN_THR:  open_thr  = i_cfg_data[ngh_pkg::THR_W-1:0];
                    ngh_pkg::CFG_CLOSE_THR: close_thr = i_cfg_data[ngh_pkg::THR_W-1:0];
                    ngh_pkg::CFG_HOLD:      hold_len  = i_cfg_data[ngh_pkg::HOLD_W-1:0];
                    ngh_pkg::CFG_POLE:      pole      = i_cfg_data[ngh_pkg::POLE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready)
                gated_results.push_back(gate_step(i_in_ch.sample));
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (gated_results.size() == 0) begin
                    report_mismatch("result with none expected", 0, 0);
                end else begin
                    want = gated_results.pop_front();
                    if (i_out_ch.gated_sample !== want.gated)
                        report_mismatch("gated_sample", longint'(want.gated),
                                        longint'(i_out_ch.gated_sample));
                    if (i_out_ch.current_gain !== want.gain)
                        report_mismatch("current_gain", longint'(want.gain),
                                        longint'(i_out_ch.current_gain));
                    if (i_out_ch.gate_open !== want.open)
                        report_mismatch("gate_open", longint'(want.open),
                                        longint'(i_out_ch.gate_open));
                end
                result_idx++;
            end
        end
    end

endmodule

### tb/tb_noise_gate_hold_smooth.sv
// Top of the noise gate testbench: clock, reset, stimulus, receiver pacing and verdict.
`timescale 1ns / 100ps

module tb_noise_gate_hold_smooth;

    localparam int THR_MAX     = (1 << ngh_pkg::THR_W) - 1;
    localparam int HOLD_MAX    = (1 << ngh_pkg::HOLD_W) - 1;
    localparam int POLE_MAX    = (1 << ngh_pkg::POLE_W) - 1;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 36;
    localparam int RX_HOLD_LEN = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [ngh_pkg::SAMPLE_W-1:0] DIRECTED [20] = '{
        24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
        24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA,
        24'h400000, 24'hC00000, 24'h000000, 24'h000000, 24'h000000,
        24'h7FFFFE, 24'h800001, 24'h000100, 24'hFFFF00, 24'h000000
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ngh_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ngh_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int  fail_count;
    int  pending;
    int  cycles;
    bit  steady_run;
    bit  rx_hold_go;
    real env_est;
    int  burst_left;
    bit  burst_loud;

    ngh_in_if  in_if ();
    ngh_out_if out_if ();

    noise_gate_hold_smooth dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    ngh_gate_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_ch      (in_if),
        .i_out_ch     (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Pace the receiver: random stalls, one long hold-off, no stalls in the steady phase
    initial begin : rx_pacing
        int hold_cycles;
        bit rx_hold_done;
        hold_cycles  = 0;
        rx_hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else if (rx_hold_go && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                hold_cycles  = RX_HOLD_LEN;
                out_if.ready <= 1'b0;
            end else if (steady_run) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    function automatic logic [ngh_pkg::THR_W-1:0] to_thr(input int v);
        if (v < 0)
            return '0;
        if (v > THR_MAX)
            return ngh_pkg::THR_W'(THR_MAX);
        return ngh_pkg::THR_W'(v);
    endfunction

    // Draw a sample: bursts of loud and quiet audio, with some fully random words
    function automatic logic [ngh_pkg::SAMPLE_W-1:0] next_sample();
        logic [ngh_pkg::SAMPLE_W-1:0] raw;
        if (burst_left == 0) begin
            burst_loud = 1'($urandom_range(1));
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        if ($urandom_range(99) < 10)
            raw = ngh_pkg::SAMPLE_W'($urandom);
        else if (burst_loud)
            raw = {2'b01, 22'($urandom)};
        else
            raw = ngh_pkg::SAMPLE_W'($urandom_range(255));
        if ($urandom_range(1))
            raw = -raw;
        return raw;
    endfunction

    task automatic cfg_write(input ngh_pkg::t_cfg_idx idx,
                             input logic [ngh_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Insert random idle cycles before the next request
    task automatic idle_gap();
        while (!steady_run && $urandom_range(99) < 16) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Offer one sample and hold it until the request is taken
    task automatic send_sample(input logic signed [ngh_pkg::SAMPLE_W-1:0] s);
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        @(negedge i_clk);
        while (!in_if.ready)
            @(negedge i_clk);
        @(posedge i_clk);
        env_est = env_est * 0.999 + ((s < 0) ? -real'(s) : real'(s)) * 0.001;
    endtask

    // Stimulus
    initial begin : stim
        logic [ngh_pkg::THR_W-1:0]  open_v, close_v;
        logic [ngh_pkg::HOLD_W-1:0] hold_v;
        logic [ngh_pkg::POLE_W-1:0] pole_v;
        int                         est_i;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= ngh_pkg::CFG_OPEN_THR;
        i_cfg_data   <= '0;
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;
        steady_run   = 1'b0;
        rx_hold_go   = 1'b0;
        env_est      = 0.0;
        burst_left   = 0;
        burst_loud   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed extremes at the reset settings
        foreach (DIRECTED[i]) begin
            idle_gap();
            send_sample(DIRECTED[i]);
        end

        for (int k = 0; k < PHASES; k++) begin
            // Drain all results before touching the registers
            in_if.valid <= 1'b0;
            while (pending != 0)
                @(posedge i_clk);

            est_i = int'(env_est);
            case (k)
                0: begin
                    // Open and close on every sample, zero hold, pole at zero
                    open_v  = '0;
                    close_v = ngh_pkg::THR_W'(THR_MAX);
                    hold_v  = '0;
                    pole_v  = '0;
                end
                1: begin
                    // Never open, never count, longest hold, slowest pole
                    open_v  = ngh_pkg::THR_W'(THR_MAX);
                    close_v = '0;
                    hold_v  = ngh_pkg::HOLD_W'(HOLD_MAX);
                    pole_v  = ngh_pkg::POLE_W'(POLE_MAX);
                end
                default: begin
                    if (k % 3 == 0) begin
                        // Close level above open level around the current envelope
                        open_v  = to_thr(est_i - int'($urandom_range(20000)));
                        close_v = to_thr(est_i + int'($urandom_range(20000)));
                    end else begin
                        // Narrow hysteresis band near the current envelope
                        open_v  = to_thr(est_i + int'($urandom_range(30000)) - 8000);
                        close_v = to_thr(int'(open_v) - int'($urandom_range(6000)));
                    end
                    hold_v = ngh_pkg::HOLD_W'($urandom_range(8));
                    case ($urandom_range(3))
                        0:       pole_v = '0;
                        1:       pole_v = ngh_pkg::POLE_W'(POLE_MAX);
                        default: pole_v = ngh_pkg::POLE_W'($urandom_range(65535, 49152));
                    endcase
                end
            endcase

            // Write all registers, with junk above the narrow ones
            cfg_write(ngh_pkg::CFG_OPEN_THR, ngh_pkg::CFG_DATA_W'(open_v));
            cfg_write(ngh_pkg::CFG_CLOSE_THR, ngh_pkg::CFG_DATA_W'(close_v));
            cfg_write(ngh_pkg::CFG_HOLD,
                      {(ngh_pkg::CFG_DATA_W - ngh_pkg::HOLD_W)'($urandom), hold_v});
            cfg_write(ngh_pkg::CFG_POLE,
                      {(ngh_pkg::CFG_DATA_W - ngh_pkg::POLE_W)'($urandom), pole_v});
            i_cfg_we <= 1'b0;

            steady_run = (k == 2);
            rx_hold_go = rx_hold_go || (k == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_gap();
                send_sample(next_sample());
            end
            steady_run = 1'b0;
        end

        // Drain and let the pipeline run empty
        in_if.valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
